// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/crfal_pkg.sv -----
// ----------------------------------------------------------------------------
// crfal_pkg
// Shared types and command codes for the register file, ALU and load unit.
// ----------------------------------------------------------------------------
package crfal_pkg;

  localparam logic [5:0] CmdNop      = 6'd0;
  localparam logic [5:0] CmdLdRN     = 6'd1;
  localparam logic [5:0] CmdLdRR     = 6'd2;
  localparam logic [5:0] CmdLdRHl    = 6'd3;
  localparam logic [5:0] CmdLdHlR    = 6'd4;
  localparam logic [5:0] CmdLdHlN    = 6'd5;
  localparam logic [5:0] CmdLdABc    = 6'd6;
  localparam logic [5:0] CmdLdADe    = 6'd7;
  localparam logic [5:0] CmdLdANn    = 6'd8;
  localparam logic [5:0] CmdLdBcA    = 6'd9;
  localparam logic [5:0] CmdLdDeA    = 6'd10;
  localparam logic [5:0] CmdLdNnA    = 6'd11;
  localparam logic [5:0] CmdLdhAN    = 6'd12;
  localparam logic [5:0] CmdLdhNA    = 6'd13;
  localparam logic [5:0] CmdLdhAC    = 6'd14;
  localparam logic [5:0] CmdLdhCA    = 6'd15;
  localparam logic [5:0] CmdLdiHlA   = 6'd16;
  localparam logic [5:0] CmdLdiAHl   = 6'd17;
  localparam logic [5:0] CmdLddHlA   = 6'd18;
  localparam logic [5:0] CmdLddAHl   = 6'd19;
  localparam logic [5:0] CmdLdRrNn   = 6'd20;
  localparam logic [5:0] CmdLdSpHl   = 6'd21;
  localparam logic [5:0] CmdPush     = 6'd22;
  localparam logic [5:0] CmdPop      = 6'd23;
  localparam logic [5:0] CmdAluFirst = 6'd24;
  localparam logic [5:0] CmdAluLast  = 6'd44;

  localparam logic [15:0] HighPage = 16'hFF00;

  typedef enum logic [3:0] {
    OP_NOP, OP_LD_REG, OP_ST, OP_LD_PAIR, OP_LD_SP_HL, OP_PUSH, OP_POP, OP_ALU
  } op_kind_e;

  typedef enum logic [1:0] {
    ADDR_NONE, ADDR_HL, ADDR_BC, ADDR_DE
  } addr_src_e;

  typedef enum logic [2:0] {
    A_ADD, A_ADC, A_SUB, A_SBC, A_AND, A_XOR, A_OR
  } alu_op_e;

  // Operand byte for loads, stores and the ALU.
  typedef enum logic [1:0] {
    B_REG, B_IMM, B_MEM, B_ACC
  } byte_src_e;

  typedef enum logic [1:0] {
    AM_NONE, AM_PAIR, AM_ABS, AM_HIGH_C
  } addr_mode_e;

  typedef enum logic [1:0] {
    HL_KEEP, HL_INC, HL_DEC
  } hl_step_e;

  typedef struct packed {
    op_kind_e   kind;
    addr_mode_e amode;
    addr_src_e  apair;
    logic       rd;
    logic       wr;
    byte_src_e  bsrc;
    logic       to_acc;
    hl_step_e   hl_step;
    alu_op_e    alu_op;
    logic [4:0] cyc;
    logic [2:0] dst;
    logic [2:0] src;
    logic [1:0] rp;
    logic [15:0] nn;
    logic [7:0]  imm;
    logic [15:0] md;
  } uop_t;

endpackage

// ----- hw/rtl/crfal_front.sv -----
// ----------------------------------------------------------------------------
// crfal_front
// Accepts instruction items and decodes them into micro-operations.
// ----------------------------------------------------------------------------
module crfal_front (
  input  logic        [5:0]  command_i,
  input  logic        [7:0]  opcode_i,
  input  logic        [7:0]  imm8_i,
  input  logic        [15:0] imm16_i,
  input  logic        [15:0] mem_data_i,
  output crfal_pkg::uop_t    uop_o
);

  logic [5:0] k;
  logic [2:0] op_q3;
  logic [1:0] s_q3;

  // Split the ALU code into op and source by a small table.
  always_comb begin
    k = command_i - crfal_pkg::CmdAluFirst;
    op_q3 = 3'd0;
    s_q3  = 2'd0;
    if (k < 6'd3)       begin op_q3 = 3'd0; s_q3 = 2'(k); end
    else if (k < 6'd6)  begin op_q3 = 3'd1; s_q3 = 2'(k - 6'd3); end
    else if (k < 6'd9)  begin op_q3 = 3'd2; s_q3 = 2'(k - 6'd6); end
    else if (k < 6'd12) begin op_q3 = 3'd3; s_q3 = 2'(k - 6'd9); end
    else if (k < 6'd15) begin op_q3 = 3'd4; s_q3 = 2'(k - 6'd12); end
    else if (k < 6'd18) begin op_q3 = 3'd5; s_q3 = 2'(k - 6'd15); end
    else                begin op_q3 = 3'd6; s_q3 = 2'(k - 6'd18); end
  end

  always_comb begin
    uop_o = '0;
    uop_o.kind    = crfal_pkg::OP_NOP;
    uop_o.amode   = crfal_pkg::AM_NONE;
    uop_o.apair   = crfal_pkg::ADDR_NONE;
    uop_o.bsrc    = crfal_pkg::B_REG;
    uop_o.hl_step = crfal_pkg::HL_KEEP;
    uop_o.alu_op  = crfal_pkg::A_ADD;
    uop_o.cyc     = 5'd4;
    uop_o.dst     = opcode_i[5:3];
    uop_o.src     = opcode_i[2:0];
    uop_o.rp      = opcode_i[5:4];
    uop_o.nn      = imm16_i;
    uop_o.imm     = imm8_i;
    uop_o.md      = mem_data_i;
    unique case (command_i)
      crfal_pkg::CmdLdRN: begin
        uop_o.kind = crfal_pkg::OP_LD_REG; uop_o.bsrc = crfal_pkg::B_IMM; uop_o.cyc = 5'd8;
      end
      crfal_pkg::CmdLdRR: begin
        uop_o.kind = crfal_pkg::OP_LD_REG; uop_o.bsrc = crfal_pkg::B_REG;
      end
      crfal_pkg::CmdLdRHl: begin
        uop_o.kind = crfal_pkg::OP_LD_REG; uop_o.bsrc = crfal_pkg::B_MEM; uop_o.cyc = 5'd8;
        uop_o.amode = crfal_pkg::AM_PAIR; uop_o.apair = crfal_pkg::ADDR_HL; uop_o.rd = 1'b1;
      end
      crfal_pkg::CmdLdHlR: begin
        uop_o.kind = crfal_pkg::OP_ST; uop_o.bsrc = crfal_pkg::B_REG; uop_o.cyc = 5'd8;
        uop_o.amode = crfal_pkg::AM_PAIR; uop_o.apair = crfal_pkg::ADDR_HL; uop_o.wr = 1'b1;
      end
      crfal_pkg::CmdLdHlN: begin
        uop_o.kind = crfal_pkg::OP_ST; uop_o.bsrc = crfal_pkg::B_IMM; uop_o.cyc = 5'd12;
        uop_o.amode = crfal_pkg::AM_PAIR; uop_o.apair = crfal_pkg::ADDR_HL; uop_o.wr = 1'b1;
      end
      crfal_pkg::CmdLdABc, crfal_pkg::CmdLdADe, crfal_pkg::CmdLdiAHl,
      crfal_pkg::CmdLddAHl: begin
        uop_o.kind = crfal_pkg::OP_LD_REG; uop_o.bsrc = crfal_pkg::B_MEM; uop_o.cyc = 5'd8;
        uop_o.to_acc = 1'b1; uop_o.amode = crfal_pkg::AM_PAIR; uop_o.rd = 1'b1;
        uop_o.apair = (command_i == crfal_pkg::CmdLdABc) ? crfal_pkg::ADDR_BC :
                      (command_i == crfal_pkg::CmdLdADe) ? crfal_pkg::ADDR_DE :
                      crfal_pkg::ADDR_HL;
        uop_o.hl_step = (command_i == crfal_pkg::CmdLdiAHl) ? crfal_pkg::HL_INC :
                        (command_i == crfal_pkg::CmdLddAHl) ? crfal_pkg::HL_DEC :
                        crfal_pkg::HL_KEEP;
      end
      crfal_pkg::CmdLdBcA, crfal_pkg::CmdLdDeA, crfal_pkg::CmdLdiHlA,
      crfal_pkg::CmdLddHlA: begin
        uop_o.kind = crfal_pkg::OP_ST; uop_o.bsrc = crfal_pkg::B_ACC; uop_o.cyc = 5'd8;
        uop_o.amode = crfal_pkg::AM_PAIR; uop_o.wr = 1'b1;
        uop_o.apair = (command_i == crfal_pkg::CmdLdBcA) ? crfal_pkg::ADDR_BC :
                      (command_i == crfal_pkg::CmdLdDeA) ? crfal_pkg::ADDR_DE :
                      crfal_pkg::ADDR_HL;
        uop_o.hl_step = (command_i == crfal_pkg::CmdLdiHlA) ? crfal_pkg::HL_INC :
                        (command_i == crfal_pkg::CmdLddHlA) ? crfal_pkg::HL_DEC :
                        crfal_pkg::HL_KEEP;
      end
      crfal_pkg::CmdLdANn, crfal_pkg::CmdLdhAN, crfal_pkg::CmdLdhAC: begin
        uop_o.kind = crfal_pkg::OP_LD_REG; uop_o.bsrc = crfal_pkg::B_MEM;
        uop_o.to_acc = 1'b1; uop_o.rd = 1'b1;
        if (command_i == crfal_pkg::CmdLdANn) begin
          uop_o.amode = crfal_pkg::AM_ABS; uop_o.cyc = 5'd16;
        end else if (command_i == crfal_pkg::CmdLdhAN) begin
          uop_o.amode = crfal_pkg::AM_ABS; uop_o.cyc = 5'd12;
          uop_o.nn = crfal_pkg::HighPage | {8'h00, imm8_i};
        end else begin
          uop_o.amode = crfal_pkg::AM_HIGH_C; uop_o.cyc = 5'd8;
        end
      end
      crfal_pkg::CmdLdNnA, crfal_pkg::CmdLdhNA, crfal_pkg::CmdLdhCA: begin
        uop_o.kind = crfal_pkg::OP_ST; uop_o.bsrc = crfal_pkg::B_ACC; uop_o.wr = 1'b1;
        if (command_i == crfal_pkg::CmdLdNnA) begin
          uop_o.amode = crfal_pkg::AM_ABS; uop_o.cyc = 5'd16;
        end else if (command_i == crfal_pkg::CmdLdhNA) begin
          uop_o.amode = crfal_pkg::AM_ABS; uop_o.cyc = 5'd12;
          uop_o.nn = crfal_pkg::HighPage | {8'h00, imm8_i};
        end else begin
          uop_o.amode = crfal_pkg::AM_HIGH_C; uop_o.cyc = 5'd8;
        end
      end
      crfal_pkg::CmdLdRrNn: begin
        uop_o.kind = crfal_pkg::OP_LD_PAIR; uop_o.cyc = 5'd12;
      end
      crfal_pkg::CmdLdSpHl: begin
        uop_o.kind = crfal_pkg::OP_LD_SP_HL; uop_o.cyc = 5'd8;
      end
      crfal_pkg::CmdPush: begin
        uop_o.kind = crfal_pkg::OP_PUSH; uop_o.cyc = 5'd16; uop_o.wr = 1'b1;
      end
      crfal_pkg::CmdPop: begin
        uop_o.kind = crfal_pkg::OP_POP; uop_o.cyc = 5'd12; uop_o.rd = 1'b1;
      end
      default: begin
        if (command_i >= crfal_pkg::CmdAluFirst && command_i <= crfal_pkg::CmdAluLast) begin
          uop_o.kind = crfal_pkg::OP_ALU;
          uop_o.alu_op = crfal_pkg::alu_op_e'(op_q3);
          unique case (s_q3)
            2'd0: uop_o.bsrc = crfal_pkg::B_REG;
            2'd1: begin uop_o.bsrc = crfal_pkg::B_IMM; uop_o.cyc = 5'd8; end
            default: begin
              uop_o.bsrc = crfal_pkg::B_MEM; uop_o.cyc = 5'd8; uop_o.rd = 1'b1;
              uop_o.amode = crfal_pkg::AM_PAIR; uop_o.apair = crfal_pkg::ADDR_HL;
            end
          endcase
        end
      end
    endcase
  end

endmodule

// ----- hw/rtl/crfal_queue.sv -----
// ----------------------------------------------------------------------------
// crfal_queue
// Two-entry queue of decoded micro-operations between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crfal_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  crfal_pkg::uop_t  push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output crfal_pkg::uop_t  pop_data_o
);

  crfal_pkg::uop_t mem_q [2];
  logic wptr_q, rptr_q;
  logic [1:0] count_q;

  assign full_o      = (count_q == 2'd2);
  assign pop_valid_o = (count_q != 2'd0);
  assign pop_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `ASSERT_CLK(a_no_overflow, clk_i, rst_ni, push_i |-> !full_o, "queue overflow")
  `ASSERT_CLK(a_no_underflow, clk_i, rst_ni, pop_i |-> pop_valid_o, "queue underflow")
  `ASSERT_CLK(a_count_max, clk_i, rst_ni, count_q != 2'd3, "queue count out of range")

endmodule

// ----- hw/rtl/crfal_back.sv -----
// ----------------------------------------------------------------------------
// crfal_back
// Register file, address generation and 8-bit ALU; one micro-op per cycle while exec_i is high.
// ----------------------------------------------------------------------------
module crfal_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             exec_i,
  input  crfal_pkg::uop_t  uop_i,
  output logic [15:0]      mem_addr_o,
  output logic             mem_read_o,
  output logic             mem_write_o,
  output logic             mem_word_o,
  output logic [15:0]      write_data_o,
  output logic [4:0]       cycle_count_o,
  output logic [7:0]       acc_value_o,
  output logic [7:0]       flag_value_o
);

  logic [15:0] af_q, bc_q, de_q, hl_q, sp_q;
  logic [15:0] af_d, bc_d, de_d, hl_d, sp_d;
  logic [7:0]  src_byte, opnd, alu_r;
  logic [15:0] pair_v, addr;
  logic [4:0]  lo_sum;
  logic [8:0]  sum;
  logic        cin, ci, hf, cf, nf;

  function automatic logic [7:0] reg_rd(input logic [2:0] idx, input logic [15:0] af,
                                        input logic [15:0] bc, input logic [15:0] de,
                                        input logic [15:0] hl);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = bc[15:8];
      3'd1: r = bc[7:0];
      3'd2: r = de[15:8];
      3'd3: r = de[7:0];
      3'd4: r = hl[15:8];
      3'd5: r = hl[7:0];
      3'd6: r = af[7:0];
      default: r = af[15:8];
    endcase
    return r;
  endfunction

  always_comb begin
    src_byte = reg_rd(uop_i.src, af_q, bc_q, de_q, hl_q);
    unique case (uop_i.bsrc)
      crfal_pkg::B_REG: opnd = src_byte;
      crfal_pkg::B_IMM: opnd = uop_i.imm;
      crfal_pkg::B_MEM: opnd = uop_i.md[7:0];
      default:          opnd = af_q[15:8];
    endcase
    unique case (uop_i.rp)
      2'd0: pair_v = bc_q;
      2'd1: pair_v = de_q;
      2'd2: pair_v = hl_q;
      default: pair_v = sp_q;
    endcase
  end

  // ALU
  always_comb begin
    cin = af_q[4];
    ci  = 1'b0;
    nf  = 1'b0;
    hf  = 1'b0;
    cf  = 1'b0;
    sum = '0;
    lo_sum = '0;
    alu_r = '0;
    unique case (uop_i.alu_op)
      crfal_pkg::A_ADD, crfal_pkg::A_ADC: begin
        ci = (uop_i.alu_op == crfal_pkg::A_ADC) & cin;
        sum = {1'b0, af_q[15:8]} + {1'b0, opnd} + 9'(ci);
        lo_sum = {1'b0, af_q[11:8]} + {1'b0, opnd[3:0]} + 5'(ci);
        alu_r = sum[7:0];
        hf = lo_sum[4];
        cf = sum[8];
      end
      crfal_pkg::A_SUB, crfal_pkg::A_SBC: begin
        ci = (uop_i.alu_op == crfal_pkg::A_SBC) & cin;
        sum = {1'b0, af_q[15:8]} - {1'b0, opnd} - 9'(ci);
        lo_sum = {1'b0, af_q[11:8]} - {1'b0, opnd[3:0]} - 5'(ci);
        alu_r = sum[7:0];
        nf = 1'b1;
        hf = lo_sum[4];
        cf = sum[8];
      end
      crfal_pkg::A_AND: begin alu_r = af_q[15:8] & opnd; hf = 1'b1; end
      crfal_pkg::A_XOR: alu_r = af_q[15:8] ^ opnd;
      default:          alu_r = af_q[15:8] | opnd;
    endcase
  end

  always_comb begin
    unique case (uop_i.apair)
      crfal_pkg::ADDR_BC: addr = bc_q;
      crfal_pkg::ADDR_DE: addr = de_q;
      default:            addr = hl_q;
    endcase
  end

  always_comb begin
    af_d = af_q; bc_d = bc_q; de_d = de_q; hl_d = hl_q; sp_d = sp_q;
    mem_addr_o = '0;
    write_data_o = '0;
    mem_word_o = 1'b0;
    unique case (uop_i.amode)
      crfal_pkg::AM_PAIR:   mem_addr_o = addr;
      crfal_pkg::AM_ABS:    mem_addr_o = uop_i.nn;
      crfal_pkg::AM_HIGH_C: mem_addr_o = crfal_pkg::HighPage | {8'h00, bc_q[7:0]};
      default:              mem_addr_o = '0;
    endcase
    unique case (uop_i.kind)
      crfal_pkg::OP_LD_REG: begin
        if (uop_i.to_acc) af_d[15:8] = opnd;
        else begin
          unique case (uop_i.dst)
            3'd0: bc_d[15:8] = opnd;
            3'd1: bc_d[7:0]  = opnd;
            3'd2: de_d[15:8] = opnd;
            3'd3: de_d[7:0]  = opnd;
            3'd4: hl_d[15:8] = opnd;
            3'd5: hl_d[7:0]  = opnd;
            3'd6: af_d[7:0]  = opnd;
            default: af_d[15:8] = opnd;
          endcase
        end
      end
      crfal_pkg::OP_ST: write_data_o = {8'h00, opnd};
      crfal_pkg::OP_LD_PAIR: begin
        unique case (uop_i.rp)
          2'd0: bc_d = uop_i.nn;
          2'd1: de_d = uop_i.nn;
          2'd2: hl_d = uop_i.nn;
          default: sp_d = uop_i.nn;
        endcase
      end
      crfal_pkg::OP_LD_SP_HL: sp_d = hl_q;
      crfal_pkg::OP_PUSH: begin
        sp_d = sp_q - 16'd2;
        mem_addr_o = sp_d;
        write_data_o = pair_v;
        mem_word_o = 1'b1;
      end
      crfal_pkg::OP_POP: begin
        mem_addr_o = sp_q;
        mem_word_o = 1'b1;
        sp_d = sp_q + 16'd2;
        unique case (uop_i.rp)
          2'd0: bc_d = uop_i.md;
          2'd1: de_d = uop_i.md;
          2'd2: hl_d = uop_i.md;
          default: sp_d = uop_i.md;
        endcase
      end
      crfal_pkg::OP_ALU: begin
        af_d = {alu_r, (alu_r == 8'h00), nf, hf, cf, af_q[3:0]};
      end
      default: ;
    endcase
    unique case (uop_i.hl_step)
      crfal_pkg::HL_INC: hl_d = hl_q + 16'd1;
      crfal_pkg::HL_DEC: hl_d = hl_q - 16'd1;
      default: ;
    endcase
  end

  assign mem_read_o    = uop_i.rd;
  assign mem_write_o   = uop_i.wr;
  assign cycle_count_o = uop_i.cyc;
  assign acc_value_o   = af_d[15:8];
  assign flag_value_o  = af_d[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q <= '0; bc_q <= '0; de_q <= '0; hl_q <= '0; sp_q <= '0;
    end else if (exec_i) begin
      af_q <= af_d; bc_q <= bc_d; de_q <= de_d; hl_q <= hl_d; sp_q <= sp_d;
    end
  end

endmodule

// ----- hw/rtl/cpu_register_file_alu_and_loads_top.sv -----
// ----------------------------------------------------------------------------
// cpu_register_file_alu_and_loads_top
// Executes pre-decoded 8-bit CPU load/store/push/pop and ALU instructions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one decoded instruction
//   per item together with its immediates and the memory read data.
//   Output channel (out_valid_o / out_stall_i) returns one result item per
//   instruction: memory access, cycle cost, and A and F afterwards.
//   The front decodes into a two-entry queue; the back reads the queue head,
//   updates the register file and loads the output register in the same cycle.
//   An accepted item is registered in the queue and then in the output register.
//   Throughput: one item per cycle while the receiver does not stall.
//   When the receiver stalls, the output register holds, the queue fills,
//   and in_stall_o rises once it is full.
//   Reset clears AF, BC, DE, HL, SP, the queue and the output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cpu_register_file_alu_and_loads_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  command_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  imm8_i,
  input  logic [15:0] imm16_i,
  input  logic [15:0] mem_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] mem_addr_o,
  output logic        mem_read_o,
  output logic        mem_write_o,
  output logic        mem_word_o,
  output logic [15:0] write_data_o,
  output logic [4:0]  cycle_count_o,
  output logic [7:0]  acc_value_o,
  output logic [7:0]  flag_value_o
);

  crfal_pkg::uop_t dec_uop, head_uop;
  logic q_full, q_valid, push, exec, out_free;
  logic [15:0] b_addr, b_wdata;
  logic b_rd, b_wr, b_word;
  logic [4:0] b_cyc;
  logic [7:0] b_acc, b_flag;

  assign in_stall_o = q_full;
  assign push       = in_valid_i & ~q_full;
  assign out_free   = ~out_valid_o | ~out_stall_i;
  assign exec       = q_valid & out_free;

  crfal_front u_front (
    .command_i  (command_i),
    .opcode_i   (opcode_i),
    .imm8_i     (imm8_i),
    .imm16_i    (imm16_i),
    .mem_data_i (mem_data_i),
    .uop_o      (dec_uop)
  );

  crfal_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (dec_uop),
    .full_o      (q_full),
    .pop_valid_o (q_valid),
    .pop_i       (exec),
    .pop_data_o  (head_uop)
  );

  crfal_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .exec_i        (exec),
    .uop_i         (head_uop),
    .mem_addr_o    (b_addr),
    .mem_read_o    (b_rd),
    .mem_write_o   (b_wr),
    .mem_word_o    (b_word),
    .write_data_o  (b_wdata),
    .cycle_count_o (b_cyc),
    .acc_value_o   (b_acc),
    .flag_value_o  (b_flag)
  );

  always_ff @(posedge clk_i) begin
    if (exec) begin
      mem_addr_o    <= b_addr;
      mem_read_o    <= b_rd;
      mem_write_o   <= b_wr;
      mem_word_o    <= b_word;
      write_data_o  <= b_wdata;
      cycle_count_o <= b_cyc;
      acc_value_o   <= b_acc;
      flag_value_o  <= b_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (out_free) out_valid_o <= q_valid;
  end

  `ASSERT_CLK(a_hold_on_stall, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(acc_value_o), "output lost")
  `ASSERT_CLK(a_exec_when_free, clk_i, rst_ni, exec |-> out_free, "exec into busy output")
  `ASSERT_CLK(a_cycle_legal, clk_i, rst_ni,
    out_valid_o |-> (cycle_count_o == 5'd4 || cycle_count_o == 5'd8 ||
    cycle_count_o == 5'd12 || cycle_count_o == 5'd16), "bad cycle count")

endmodule
